[rtl/core/cdms_pkg.sv]
// Shared types and constants for the closest display mode search unit.
// Holds the field widths, the controller state type and the command and
// status structs that join the controller and the datapath. No dependencies.
package cdms_pkg;

   // Field widths
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned IDX_W   = 6;
   localparam int unsigned DIM_W   = 16;
   localparam int unsigned BPP_W   = 8;
   localparam int unsigned CNT_W   = 7;   // mode_count and the scan counter
   localparam int unsigned ENTRY_W = 2 * DIM_W + BPP_W;

   // Packed stream payload widths (whole bytes)
   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 48;

   // Arithmetic widths
   localparam int unsigned PROD_W   = 40;  // width * height * bpp
   localparam int unsigned SCALED_W = 47;  // difference * 100
   localparam int unsigned MUL_A_W  = 40;
   localparam int unsigned MUL_B_W  = 16;
   localparam int unsigned QUO_W    = 10;  // closeness factor, always below 1024
   localparam int unsigned STEP_W   = 4;
   localparam int unsigned DIV_W    = PROD_W + QUO_W - 1;

   localparam int unsigned MAX_MODES_DEFAULT = 64;

   localparam logic [QUO_W-1:0]  FACTOR_LIMIT = 10'd1000;
   localparam logic [MUL_B_W-1:0] FACTOR_SCALE = 16'd100;

   // Request kinds carried in req_tuser
   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD = 2'd0,
      MODE_FIND = 2'd1,
      MODE_INFO = 2'd2
   } mode_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RMUL1,
      ST_RMUL2,
      ST_RSTORE,
      ST_SCAN,
      ST_ENT,
      ST_EMUL,
      ST_DIFF,
      ST_RANGE,
      ST_DIV,
      ST_CMP,
      ST_FETCH,
      ST_RESP_ENTRY,
      ST_RESP_ECHO,
      ST_RESP_FAIL
   } state_type;

   // Shared multiplier operand selection
   typedef enum logic [2:0] {
      MUL_HOLD,
      MUL_REQ_WH,
      MUL_REQ_BPP,
      MUL_ENT_WH,
      MUL_ENT_BPP,
      MUL_SCALE
   } mul_sel_type;

   // Table read address source
   typedef enum logic {
      RD_SCAN,
      RD_BEST
   } rd_sel_type;

   // Result source
   typedef enum logic [1:0] {
      RES_FAIL,
      RES_ECHO,
      RES_ENTRY
   } res_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic        capture;
      logic        mem_we;
      rd_sel_type  rd_sel;
      mul_sel_type mul_sel;
      logic        reqprod_ld;
      logic        scan_init;
      logic        scan_next;
      logic        best_from_idx;
      logic        best_from_cnt;
      logic        div_init;
      logic        div_step;
      logic        best_cmp;
      logic        res_ld;
      res_sel_type res_sel;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [MODE_W-1:0] op;
      logic              load_bad;
      logic              info_bad;
      logic              req_zero;
      logic              exact;
      logic              scan_done;
      logic              out_range;
      logic              div_last;
      logic              have;
      logic              out_busy;
   } stat_type;

endpackage

[rtl/core/cdms_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Used for the display mode table. No package dependencies.
module cdms_ram #(
   parameter int unsigned WIDTH = 40,
   parameter int unsigned DEPTH = 64,
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[rtl/core/cdms_datapath.sv]
// Datapath of the closest display mode search: request capture, mode table,
// shared multiplier, bit-serial factor divider, best tracking and result register.
// Depends on cdms_pkg and cdms_ram.
module cdms_datapath import cdms_pkg::*; #(
   parameter int unsigned MAX_MODES = MAX_MODES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [MODE_W-1:0]     req_tuser,
   input  logic                  csr_valid,
   input  logic [CNT_W-1:0]      csr_wdata,
   input  cmd_type               cmd,
   output stat_type              stat,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   localparam int unsigned AW = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
   localparam int unsigned XW = (AW > CNT_W) ? AW : CNT_W;

   // Captured request
   logic [MODE_W-1:0] op_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [DIM_W-1:0]  w_ff;
   logic [DIM_W-1:0]  h_ff;
   logic [BPP_W-1:0]  b_ff;

   // Configuration
   logic [CNT_W-1:0] mode_count_ff, mode_count_in;
   logic [CNT_W-1:0] used_n;

   // Scan and best tracking
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  best_idx_ff, best_idx_in;
   logic [QUO_W-1:0]  best_factor_ff, best_factor_in;
   logic              have_ff, have_in;

   // Arithmetic
   logic [PROD_W-1:0]           reqprod_ff, reqprod_in;
   logic [SCALED_W-1:0]         mul_ff, mul_in;
   logic [MUL_A_W-1:0]          mul_a;
   logic [MUL_B_W-1:0]          mul_b;
   logic [MUL_A_W+MUL_B_W-1:0]  mul_full;
   logic [PROD_W-1:0]           diff;
   logic [SCALED_W-1:0]         rem_ff, rem_in;
   logic [DIV_W-1:0]            dv_ff, dv_in;
   logic [QUO_W-1:0]            q_ff, q_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic                        div_ge;

   // Table
   logic [XW-1:0]      wr_x;
   logic [XW-1:0]      rd_x;
   logic [CNT_W-1:0]   rd_sel7;
   logic [ENTRY_W-1:0] ent;
   logic [DIM_W-1:0]   ent_w;
   logic [DIM_W-1:0]   ent_h;
   logic [BPP_W-1:0]   ent_bpp;

   // Result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_status_ff, rsp_status_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Hold the request fields on acceptance
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_tuser;
         idx_ff <= req_tdata[5:0];
         w_ff   <= req_tdata[21:6];
         h_ff   <= req_tdata[37:22];
         b_ff   <= req_tdata[45:38];
      end
   end

   // Configuration register and number of entries in use
   assign mode_count_in = csr_valid ? csr_wdata : mode_count_ff;
   assign used_n = (32'(mode_count_ff) < MAX_MODES) ? mode_count_ff : CNT_W'(MAX_MODES);

   // Mode table
   assign wr_x    = XW'(idx_ff);
   assign rd_sel7 = (cmd.rd_sel == RD_BEST) ? best_idx_ff : cnt_ff;
   assign rd_x    = XW'(rd_sel7);

   cdms_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_MODES)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.mem_we),
      .wr_addr (wr_x[AW-1:0]),
      .wr_data ({b_ff, h_ff, w_ff}),
      .rd_addr (rd_x[AW-1:0]),
      .rd_data (ent)
   );

   assign ent_w   = ent[DIM_W-1:0];
   assign ent_h   = ent[2*DIM_W-1:DIM_W];
   assign ent_bpp = ent[ENTRY_W-1:2*DIM_W];

   // Shared multiplier: pixel products and difference scaling
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.mul_sel)
         MUL_REQ_WH: begin
            mul_a = MUL_A_W'(w_ff);
            mul_b = h_ff;
         end
         MUL_REQ_BPP: begin
            mul_a = MUL_A_W'(mul_ff[2*DIM_W-1:0]);
            mul_b = MUL_B_W'(b_ff);
         end
         MUL_ENT_WH: begin
            mul_a = MUL_A_W'(ent_w);
            mul_b = ent_h;
         end
         MUL_ENT_BPP: begin
            mul_a = MUL_A_W'(mul_ff[2*DIM_W-1:0]);
            mul_b = MUL_B_W'(ent_bpp);
         end
         MUL_SCALE: begin
            mul_a = diff;
            mul_b = FACTOR_SCALE;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;
   assign mul_in   = (cmd.mul_sel != MUL_HOLD) ? mul_full[SCALED_W-1:0] : mul_ff;

   // Absolute difference of entry product and request product
   assign diff = (mul_ff[PROD_W-1:0] >= reqprod_ff) ? mul_ff[PROD_W-1:0] - reqprod_ff
                                                    : reqprod_ff - mul_ff[PROD_W-1:0];

   assign reqprod_in = cmd.reqprod_ld ? mul_ff[PROD_W-1:0] : reqprod_ff;

   // Restoring divider, one quotient bit a cycle, most significant first
   assign div_ge = {2'b00, rem_ff} >= dv_ff;

   always_comb begin
      rem_in  = rem_ff;
      dv_in   = dv_ff;
      q_in    = q_ff;
      step_in = step_ff;
      if (cmd.div_init) begin
         rem_in  = mul_ff;
         dv_in   = {reqprod_ff, {(QUO_W-1){1'b0}}};
         q_in    = '0;
         step_in = STEP_W'(QUO_W - 1);
      end else if (cmd.div_step) begin
         if (div_ge) begin
            rem_in = rem_ff - dv_ff[SCALED_W-1:0];
         end
         dv_in   = dv_ff >> 1;
         q_in    = {q_ff[QUO_W-2:0], div_ge};
         step_in = step_ff - 1'b1;
      end
   end

   // Scan counter and best candidate
   always_comb begin
      cnt_in         = cnt_ff;
      best_idx_in    = best_idx_ff;
      best_factor_in = best_factor_ff;
      have_in        = have_ff;
      if (cmd.scan_init) begin
         cnt_in         = '0;
         best_factor_in = FACTOR_LIMIT;
         have_in        = 1'b0;
      end else if (cmd.scan_next) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.best_from_idx) begin
         best_idx_in = CNT_W'(idx_ff);
         have_in     = 1'b1;
      end else if (cmd.best_from_cnt) begin
         best_idx_in = cnt_ff;
         have_in     = 1'b1;
      end else if (cmd.best_cmp && (q_ff < best_factor_ff)) begin
         best_idx_in    = cnt_ff;
         best_factor_in = q_ff;
         have_in        = 1'b1;
      end
   end

   // Result register: load a new transaction, drop it once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      if (cmd.res_ld) begin
         rsp_valid_in = 1'b1;
         unique case (cmd.res_sel)
            RES_ECHO: begin
               rsp_status_in = 1'b0;
               rsp_data_in   = {2'b00, b_ff, h_ff, w_ff, idx_ff};
            end
            RES_ENTRY: begin
               rsp_status_in = 1'b0;
               rsp_data_in   = {2'b00, ent_bpp, ent_h, ent_w, best_idx_ff[IDX_W-1:0]};
            end
            default: begin
               rsp_status_in = 1'b1;
               rsp_data_in   = '0;
            end
         endcase
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         have_ff       <= 1'b0;
      end else begin
         mode_count_ff <= mode_count_in;
         rsp_valid_ff  <= rsp_valid_in;
         have_ff       <= have_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cnt_ff         <= cnt_in;
      best_idx_ff    <= best_idx_in;
      best_factor_ff <= best_factor_in;
      reqprod_ff     <= reqprod_in;
      mul_ff         <= mul_in;
      rem_ff         <= rem_in;
      dv_ff          <= dv_in;
      q_ff           <= q_in;
      step_ff        <= step_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // Status towards the controller
   always_comb begin
      stat.op        = op_ff;
      stat.load_bad  = 32'(idx_ff) >= MAX_MODES;
      stat.info_bad  = CNT_W'(idx_ff) >= used_n;
      stat.req_zero  = reqprod_ff == '0;
      stat.exact     = (ent_w == w_ff) && (ent_h == h_ff) && (ent_bpp == b_ff);
      stat.scan_done = cnt_ff >= used_n;
      stat.out_range = {3'b000, mul_ff} >= {reqprod_ff, {QUO_W{1'b0}}};
      stat.div_last  = step_ff == '0;
      stat.have      = have_ff;
      stat.out_busy  = rsp_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

`ifndef NO_ASSERTIONS
   // A pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.res_ld |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result register loaded while a transaction is pending");

   // Division starts only when the quotient fits the factor width
   a_div_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.div_init |-> (!stat.out_range && !stat.req_zero))
      else $error("factor division started out of range");

   // Best factor never rises above the limit during a scan
   a_best_limit: assert property (@(posedge clock) disable iff (reset)
      cmd.best_cmp |-> (best_factor_ff <= FACTOR_LIMIT))
      else $error("best factor above limit");

   // Table writes stay inside the table
   a_write_range: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_we |-> (32'(idx_ff) < MAX_MODES))
      else $error("table write beyond its depth");
`endif

endmodule

[rtl/core/cdms_ctrl.sv]
// Controller of the closest display mode search: sequences load, info and the
// find scan over the mode table by commands to the datapath.
// Depends on cdms_pkg.
module cdms_ctrl import cdms_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (stat.op)
               MODE_LOAD: state_in = stat.load_bad ? ST_RESP_FAIL : ST_RESP_ECHO;
               MODE_FIND: state_in = ST_RMUL1;
               MODE_INFO: state_in = stat.info_bad ? ST_RESP_FAIL : ST_FETCH;
               default:   state_in = ST_RESP_FAIL;
            endcase
         end
         ST_RMUL1:  state_in = ST_RMUL2;
         ST_RMUL2:  state_in = ST_RSTORE;
         ST_RSTORE: state_in = ST_SCAN;
         ST_SCAN: begin
            if (stat.scan_done) begin
               state_in = stat.have ? ST_FETCH : ST_RESP_FAIL;
            end else begin
               state_in = ST_ENT;
            end
         end
         ST_ENT: begin
            priority if (stat.exact) state_in = ST_FETCH;
            else if (stat.req_zero)  state_in = ST_SCAN;
            else                     state_in = ST_EMUL;
         end
         ST_EMUL:  state_in = ST_DIFF;
         ST_DIFF:  state_in = ST_RANGE;
         ST_RANGE: state_in = stat.out_range ? ST_SCAN : ST_DIV;
         ST_DIV: begin
            if (stat.div_last) state_in = ST_CMP;
         end
         ST_CMP:   state_in = ST_SCAN;
         ST_FETCH: state_in = ST_RESP_ENTRY;
         ST_RESP_ENTRY, ST_RESP_ECHO, ST_RESP_FAIL: begin
            if (!stat.out_busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd            = '0;
      cmd.rd_sel     = RD_SCAN;
      cmd.mul_sel    = MUL_HOLD;
      cmd.res_sel    = RES_FAIL;
      req_tready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_DECODE: begin
            cmd.mem_we        = (stat.op == MODE_LOAD) && !stat.load_bad;
            cmd.best_from_idx = (stat.op == MODE_INFO) && !stat.info_bad;
         end
         ST_RMUL1:  cmd.mul_sel = MUL_REQ_WH;
         ST_RMUL2:  cmd.mul_sel = MUL_REQ_BPP;
         ST_RSTORE: begin
            cmd.reqprod_ld = 1'b1;
            cmd.scan_init  = 1'b1;
         end
         ST_SCAN: ;
         ST_ENT: begin
            priority if (stat.exact) cmd.best_from_cnt = 1'b1;
            else if (stat.req_zero)  cmd.scan_next     = 1'b1;
            else                     cmd.mul_sel       = MUL_ENT_WH;
         end
         ST_EMUL: cmd.mul_sel = MUL_ENT_BPP;
         ST_DIFF: cmd.mul_sel = MUL_SCALE;
         ST_RANGE: begin
            if (stat.out_range) cmd.scan_next = 1'b1;
            else                cmd.div_init  = 1'b1;
         end
         ST_DIV: cmd.div_step = 1'b1;
         ST_CMP: begin
            cmd.best_cmp  = 1'b1;
            cmd.scan_next = 1'b1;
         end
         ST_FETCH: cmd.rd_sel = RD_BEST;
         ST_RESP_ENTRY: begin
            cmd.rd_sel  = RD_BEST;
            cmd.res_sel = RES_ENTRY;
            cmd.res_ld  = !stat.out_busy;
         end
         ST_RESP_ECHO: begin
            cmd.res_sel = RES_ECHO;
            cmd.res_ld  = !stat.out_busy;
         end
         ST_RESP_FAIL: begin
            cmd.res_sel = RES_FAIL;
            cmd.res_ld  = !stat.out_busy;
         end
         default: ;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/closest_display_mode_search_unit.sv]
// Channel  Direction  Handshake                 Payload
// req      in         req_tvalid / req_tready   req_tdata, req_tuser (request kind)
// rsp      out        rsp_tvalid / rsp_tready   rsp_tdata, rsp_tuser (status)
// csr      in         csr_valid / csr_ready     csr_wdata (mode_count)
//
// One request is in work at a time. Find forms the request product, then scans
// the table: an exact match ends the scan, a zero request skips each entry, a factor
// of 1024 or more rejects it, else a 10-step division gives the factor to compare.
// Reset is synchronous and clears control state; the mode table is not cleared.
// A result waits in the output register while rsp_tready is low; the next request
// is taken meanwhile and held at its result step.
// Top level of the closest display mode search; depends on cdms_pkg,
// cdms_ctrl and cdms_datapath.
module closest_display_mode_search_unit import cdms_pkg::*; #(
   parameter int unsigned MAX_MODES = MAX_MODES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [5:0] entry_index, [21:6] req_width, [37:22] req_height, [45:38] req_bpp
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] mode
   input  logic [MODE_W-1:0]     req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [5:0] found_index, [21:6] res_width, [37:22] res_height, [45:38] res_bpp
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] status
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CNT_W-1:0]      csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   // Register writes are taken in every cycle
   assign csr_ready = 1'b1;

   cdms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cdms_datapath #(
      .MAX_MODES (MAX_MODES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
